>>> src/lupf_pkg.sv
// Shared types and constants for the LU partial-pivot factor block.
// No dependencies.
package lupf_pkg;
    localparam int MaxOrderDefault  = 8;
    localparam int DataWidthDefault = 32;
    localparam int FracBits         = 16;
    localparam int CfgWidth         = 4;
    localparam int LuWidth          = 32;
    localparam int IdxWidth         = 3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SRCH_RD,
        ST_SRCH,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_PIV_RD,
        ST_DIV,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_OUT_RD,
        ST_OUT
    } lupf_state_t;

    typedef struct packed {
        logic start;
        logic neg;
    } lupf_div_ctl_t;
endpackage

>>> src/lupf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lupf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/lupf_div.sv
// Restoring divider, one quotient bit per cycle, saturating Q-format result.
// Depends on lupf_pkg.
module lupf_div #(
    parameter int DW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lupf_pkg::lupf_div_ctl_t ctl,
    input  logic [DW-1:0]         num_mag,
    input  logic [DW-1:0]         den_mag,
    output logic                  done,
    output logic signed [DW-1:0]  quot
);
    import lupf_pkg::*;

    localparam int NW = DW + FracBits;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic [DW+1:0] trial;
    logic [NW-1:0] lim;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = '0;
        if (ctl.start)
        begin
            q_next    = {num_mag, {FracBits{1'b0}}};
            r_next    = '0;
            d_next    = den_mag;
            cnt_next  = CW'(NW);
            neg_next  = ctl.neg;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
            begin
                trial = {r_reg, q_reg[NW-1]} - {2'b00, d_reg};
                if (!trial[DW+1])
                begin
                    r_next = trial[DW:0];
                    q_next = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                    q_next = {q_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        lim = NW'(1) << (DW - 1);
        if (d_reg == '0 || q_reg == '0)
        begin
            quot = '0;
        end
        else if (neg_reg)
        begin
            quot = (q_reg >= lim) ? {1'b1, {(DW-1){1'b0}}} : DW'(-q_reg);
        end
        else
        begin
            quot = (q_reg >= lim) ? {1'b0, {(DW-1){1'b1}}} : DW'(q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end
endmodule

>>> src/lu_partial_pivot_factor.sv
// Top level of the LU partial-pivot factor block: sequencer, matrix RAM, divider.
// Depends on lupf_pkg, lupf_ram, lupf_div.
//
//   channel   | signals                               | direction
//   ----------+---------------------------------------+----------
//   config    | cfg_we, cfg_data                      | in
//   element   | start, busy, element                  | in
//   result    | valid, lu_value, row, col, pivot_row, | out
//             | last                                  |
//
// A beat is taken when start is high and busy is low; the last element of a
// load starts factoring, which holds busy high. Factoring is bound by the
// matrix RAM (one read, one write a cycle) and the bit-serial divider: about
// n^3/3 updates, each through read, multiply and write states, plus n^2/2
// divisions, then n*n result beats, each through a read and an output state.
// Results leave one per strobe; the receiver cannot stall. Reset clears
// control state only; RAM contents are undefined.
module lu_partial_pivot_factor #(
    parameter int MAX_ORDER  = lupf_pkg::MaxOrderDefault,
    parameter int DATA_WIDTH = lupf_pkg::DataWidthDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lupf_pkg::CfgWidth-1:0]         cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [lupf_pkg::LuWidth-1:0]   element,
    output logic                                  valid,
    output logic signed [lupf_pkg::LuWidth-1:0]   lu_value,
    output logic [lupf_pkg::IdxWidth-1:0]         row,
    output logic [lupf_pkg::IdxWidth-1:0]         col,
    output logic [lupf_pkg::IdxWidth-1:0]         pivot_row,
    output logic                                  last
);
    import lupf_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = 2 * DW;

    lupf_state_t st_reg, st_next;
    logic [CfgWidth-1:0] size_reg;
    logic [NW-1:0] n_eff;
    logic [KW-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [KW-1:0] i_reg, i_next, p_reg, p_next;
    logic [DW-1:0] best_reg, best_next;
    logic signed [DW-1:0] a_reg, a_next, piv_reg, piv_next, f_reg, f_next;
    logic signed [PW-1:0] prod_reg, prod_next;

    // matrix RAM ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    // pivot record
    logic [IdxWidth-1:0] pivs_reg [MAX_ORDER];
    logic                piv_we;

    lupf_div_ctl_t dctl;
    logic          ddone;
    logic [DW-1:0] dquot;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        mag = v[DW-1] ? DW'(-v) : v;
    endfunction

    function automatic logic [AW-1:0] addr(input logic [KW-1:0] rr,
                                           input logic [KW-1:0] cc,
                                           input logic [NW-1:0] nn);
        addr = AW'(rr * nn + cc);
    endfunction

    function automatic logic signed [DW-1:0] sat_in(input logic signed [LuWidth-1:0] v);
        logic signed [LuWidth+DW:0] w;
        logic signed [LuWidth+DW:0] hi;
        logic signed [LuWidth+DW:0] lo;
        w  = (LuWidth+DW+1)'(v);
        hi = (LuWidth+DW+1)'({1'b0, {(DW-1){1'b1}}});
        lo = -hi - 1;
        sat_in = (w > hi) ? DW'(hi) : ((w < lo) ? DW'(lo) : DW'(w));
    endfunction

    // a - floor(f*b / 2^16), saturated; prod holds f*b
    function automatic logic signed [DW-1:0] upd(input logic signed [DW-1:0] a,
                                                 input logic signed [PW-1:0] p);
        logic signed [PW+1:0] sh;
        logic signed [PW+1:0] hi;
        logic signed [PW+1:0] lo;
        logic signed [PW+1:0] mp;
        logic signed [PW+1:0] d;
        sh = (PW+2)'(p) >>> FracBits;
        hi = (PW+2)'({1'b0, {(DW-1){1'b1}}});
        lo = -hi - 1;
        mp = (sh > hi) ? hi : ((sh < lo) ? lo : sh);
        d  = (PW+2)'(a) - mp;
        upd = (d > hi) ? DW'(hi) : ((d < lo) ? DW'(lo) : DW'(d));
    endfunction

    lupf_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_mat (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    lupf_div #(.DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl),
        .num_mag(mag(rdata)), .den_mag(mag(piv_reg)),
        .done(ddone), .quot(dquot)
    );

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(size_reg) > MAX_ORDER)
        begin
            n_eff = NW'(MAX_ORDER);
        end
        else
        begin
            n_eff = NW'(size_reg);
        end
    end

    logic [KW-1:0] nm1;
    assign nm1 = KW'(n_eff - 1'b1);

    always_comb
    begin
        st_next   = st_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        k_next    = k_reg;
        i_next    = i_reg;
        p_next    = p_reg;
        best_next = best_reg;
        a_next    = a_reg;
        piv_next  = piv_reg;
        f_next    = f_reg;
        prod_next = prod_reg;
        we        = 1'b0;
        waddr     = addr(r_reg, c_reg, n_eff);
        wdata     = sat_in(element);
        raddr     = addr(i_reg, k_reg, n_eff);
        piv_we    = 1'b0;
        dctl      = '0;
        busy      = (st_reg != ST_LOAD);
        unique case (st_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    we = 1'b1;
                    if (c_reg != nm1)
                    begin
                        c_next = c_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = '0;
                        if (r_reg != nm1)
                        begin
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            r_next  = '0;
                            k_next  = '0;
                            i_next  = '0;
                            st_next = ST_SRCH_RD;
                        end
                    end
                end
            end
            ST_SRCH_RD:
            begin
                // issue read of column k for row i
                st_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                if (i_reg == k_reg || mag(rdata) > best_reg)
                begin
                    best_next = mag(rdata);
                    p_next    = i_reg;
                end
                if (i_reg == nm1)
                begin
                    piv_we  = 1'b1;
                    c_next  = '0;
                    st_next = ST_SWAP_RD;
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = ST_SRCH_RD;
                end
            end
            ST_SWAP_RD:
            begin
                if (p_reg == k_reg)
                begin
                    st_next = ST_PIV_RD;
                end
                else
                begin
                    raddr   = addr(k_reg, c_reg, n_eff);
                    st_next = ST_SWAP_WR;
                end
            end
            ST_SWAP_WR:
            begin
                // hold row k value in a; move row p over it, then a into row p
                if (i_reg == '0)
                begin
                    a_next  = rdata;
                    raddr   = addr(p_reg, c_reg, n_eff);
                    i_next  = KW'(1);
                end
                else if (i_reg == KW'(1))
                begin
                    we      = 1'b1;
                    waddr   = addr(k_reg, c_reg, n_eff);
                    wdata   = rdata;
                    i_next  = KW'(2);
                end
                else
                begin
                    we      = 1'b1;
                    waddr   = addr(p_reg, c_reg, n_eff);
                    wdata   = a_reg;
                    i_next  = '0;
                    if (c_reg == nm1)
                    begin
                        st_next = ST_PIV_RD;
                    end
                    else
                    begin
                        c_next  = c_reg + 1'b1;
                        st_next = ST_SWAP_RD;
                    end
                end
            end
            ST_PIV_RD:
            begin
                raddr = addr(k_reg, k_reg, n_eff);
                if (i_reg == '0)
                begin
                    i_next = KW'(1);
                end
                else
                begin
                    piv_next = rdata;
                    if (rdata == '0 || k_reg == nm1)
                    begin
                        k_next = k_reg + 1'b1;
                        i_next = k_reg + 1'b1;
                        st_next = (k_reg == nm1) ? ST_OUT_RD : ST_SRCH_RD;
                        if (k_reg == nm1)
                        begin
                            r_next = '0;
                            c_next = '0;
                        end
                    end
                    else
                    begin
                        i_next  = k_reg + 1'b1;
                        r_next  = '0;
                        st_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // r_reg: 0 = issue read, 1 = start divider, 2 = wait
                raddr = addr(i_reg, k_reg, n_eff);
                if (r_reg == '0)
                begin
                    r_next = KW'(1);
                end
                else if (r_reg == KW'(1))
                begin
                    dctl.start = 1'b1;
                    dctl.neg   = rdata[DW-1] ^ piv_reg[DW-1];
                    r_next     = KW'(2);
                end
                else if (ddone)
                begin
                    f_next  = dquot;
                    we      = 1'b1;
                    waddr   = addr(i_reg, k_reg, n_eff);
                    wdata   = dquot;
                    c_next  = k_reg + 1'b1;
                    st_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                // read pivot-row entry
                raddr   = addr(k_reg, c_reg, n_eff);
                st_next = ST_UPD_MUL;
            end
            ST_UPD_MUL:
            begin
                prod_next = PW'(f_reg) * PW'($signed(rdata));
                raddr     = addr(i_reg, c_reg, n_eff);
                st_next   = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                we    = 1'b1;
                waddr = addr(i_reg, c_reg, n_eff);
                wdata = upd(rdata, prod_reg);
                if (c_reg != nm1)
                begin
                    c_next  = c_reg + 1'b1;
                    st_next = ST_UPD_RD;
                end
                else if (i_reg != nm1)
                begin
                    i_next  = i_reg + 1'b1;
                    r_next  = '0;
                    st_next = ST_DIV;
                end
                else
                begin
                    k_next  = k_reg + 1'b1;
                    i_next  = k_reg + 1'b1;
                    st_next = ST_SRCH_RD;
                end
            end
            ST_OUT_RD:
            begin
                raddr   = addr(r_reg, c_reg, n_eff);
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (c_reg != nm1)
                begin
                    c_next  = c_reg + 1'b1;
                    st_next = ST_OUT_RD;
                end
                else
                begin
                    c_next = '0;
                    if (r_reg != nm1)
                    begin
                        r_next  = r_reg + 1'b1;
                        st_next = ST_OUT_RD;
                    end
                    else
                    begin
                        r_next  = '0;
                        st_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                st_next = ST_LOAD;
            end
        endcase
        if (st_reg == ST_SRCH_RD && i_reg == k_reg)
        begin
            i_next = k_reg;
        end
    end

    // search reads start at row k: SRCH_RD enters with i = k
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_LOAD;
            size_reg <= CfgWidth'(MAX_ORDER);
            r_reg    <= '0;
            c_reg    <= '0;
            k_reg    <= '0;
            i_reg    <= '0;
            valid    <= 1'b0;
        end
        else
        begin
            valid <= (st_reg == ST_OUT);
            if (cfg_we)
            begin
                size_reg <= cfg_data;
                r_reg    <= '0;
                c_reg    <= '0;
                st_reg   <= ST_LOAD;
            end
            else
            begin
                st_reg <= st_next;
                r_reg  <= r_next;
                c_reg  <= c_next;
            end
            k_reg <= k_next;
            i_reg <= (st_reg == ST_SWAP_RD && st_next == ST_PIV_RD) ? '0 :
                     (st_reg == ST_SRCH && st_next == ST_SWAP_RD) ? '0 : i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        piv_reg  <= piv_next;
        f_reg    <= f_next;
        prod_reg <= prod_next;
        if (piv_we)
        begin
            pivs_reg[k_reg] <= IdxWidth'((i_reg == k_reg || mag(rdata) > best_reg)
                                         ? i_reg : p_reg);
        end
        if (st_reg == ST_OUT)
        begin
            lu_value  <= LuWidth'($signed(rdata));
            row       <= IdxWidth'(r_reg);
            col       <= IdxWidth'(c_reg);
            pivot_row <= pivs_reg[r_reg];
            last      <= (r_reg == nm1) && (c_reg == nm1);
        end
    end
endmodule

>>> src/lupf_checker.sv
// Port-level checker for the LU partial-pivot factor block, with its bind.
// Depends on lu_partial_pivot_factor.
module lupf_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic valid,
    input logic last,
    input logic cfg_we
);
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last && valid |-> busy || $past(busy)) else $error("last outside result");
    a_no_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy)) else $error("result while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !valid) else $error("result after last");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && !busy |=> !valid) else $error("result after config");
endmodule

bind lu_partial_pivot_factor lupf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .valid(valid), .last(last), .cfg_we(cfg_we)
);

>>> tb/sv/lu_partial_pivot_factor_tb.sv
// Self-checking testbench for lu_partial_pivot_factor: loads square matrices,
// predicts the pivoted Q16.16 LU factors and checks every result beat.
// Depends on lupf_pkg and the lu_partial_pivot_factor RTL.
module lu_partial_pivot_factor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lupf_pkg::*;

    localparam int Order     = 8;
    localparam int WatchdogMax = 200000;

    // Result beat as the block presents it
    typedef struct packed {
        logic [31:0] lu_value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [2:0]  pivot_row;
        logic        last;
    } factor_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_data;
    logic        start;
    logic        busy;
    logic signed [31:0] element;
    logic        valid;
    logic signed [31:0] lu_value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [2:0]  pivot_row;
    logic        last;

    lu_partial_pivot_factor dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .element(element), .valid(valid),
        .lu_value(lu_value), .row(row), .col(col), .pivot_row(pivot_row),
        .last(last)
    );

    // Predictor state: the matrix being loaded, its order and fill count
    longint      mat [64];
    logic [2:0]  piv [8];
    int          order_sel;
    int          fill_count;
    factor_beat_t expected_beats[$];
    int          error_count;
    int          idle_pct;
    int          quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Q16.16 product: floor of the scaled product, saturated
    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = a * b;
        return sat32(p >>> 16);
    endfunction

    // Q16.16 quotient truncated toward zero, saturated; zero divisor gives zero
    function automatic longint q_div(longint a, longint b);
        longint ma;
        longint mb;
        longint q;
        if (b == 0)
            return 0;
        ma = abs64(a);
        mb = abs64(b);
        q = (ma << 16) / mb;
        if ((a < 0) != (b < 0))
            q = -q;
        return sat32(q);
    endfunction

    // Factor the loaded matrix and queue its n*n result beats
    task automatic factor_and_queue(int n);
        int p;
        longint best;
        longint t;
        longint pv;
        longint f;
        factor_beat_t b;
        for (int k = 0; k < n; k++)
        begin
            p = k;
            best = abs64(mat[k*n+k]);
            for (int i = k + 1; i < n; i++)
            begin
                if (abs64(mat[i*n+k]) > best)
                begin
                    best = abs64(mat[i*n+k]);
                    p = i;
                end
            end
            piv[k] = p[2:0];
            if (p != k)
            begin
                for (int j = 0; j < n; j++)
                begin
                    t = mat[k*n+j];
                    mat[k*n+j] = mat[p*n+j];
                    mat[p*n+j] = t;
                end
            end
            pv = mat[k*n+k];
            // Zero pivot: leave the column untouched
            if (pv != 0)
            begin
                for (int i = k + 1; i < n; i++)
                begin
                    f = q_div(mat[i*n+k], pv);
                    mat[i*n+k] = f;
                    for (int j = k + 1; j < n; j++)
                        mat[i*n+j] = sat32(mat[i*n+j] - q_mul(f, mat[k*n+j]));
                end
            end
        end
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                b.lu_value  = mat[r*n+c][31:0];
                b.row       = r[2:0];
                b.col       = c[2:0];
                b.pivot_row = piv[r];
                b.last      = (r*n + c + 1 == n*n);
                expected_beats.push_back(b);
            end
        end
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Send one element beat, with a random gap ahead of it; start stays high
    // after the beat so the next one can follow with no gap
    task automatic send_element(logic [31:0] value);
        int gap;
        int n;
        gap = 0;
        while ($urandom_range(99, 0) < idle_pct && gap < 20)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap++;
        end
        start   <= 1'b1;
        element <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        n = order_sel;
        mat[fill_count] = longint'($signed(value));
        fill_count++;
        if (fill_count == n*n)
        begin
            fill_count = 0;
            factor_and_queue(n);
        end
    endtask

    // Let the block drain, then write the order register while idle
    task automatic set_order(int value);
        int n;
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value[3:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        n = value;
        if (n < 1)
            n = 1;
        if (n > Order)
            n = Order;
        order_sel  = n;
        fill_count = 0;
    endtask

    function automatic logic [31:0] rand_element();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom();
            default: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
        endcase
    endfunction

    task automatic send_matrix(int n);
        for (int i = 0; i < n*n; i++)
            send_element(rand_element());
    endtask

    // Directed: extremes, zero pivot column, ties, order edge cases
    task automatic test_directed();
        set_order(2);
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        // zero first column drives the zero-pivot path
        send_element(32'h0);
        send_element(32'h0001_0000);
        send_element(32'h0);
        send_element(32'hffff_ffff);
        // equal magnitudes: first row wins
        send_element(32'h0001_0000);
        send_element(32'h0002_0000);
        send_element(32'hffff_0000);
        send_element(32'h0003_0000);
        // order 0 acts as 1
        set_order(0);
        send_element(32'h1234_5678);
        // order above the maximum acts as the maximum; abort a partial load
        set_order(3);
        send_element(32'h0005_0000);
        send_element(32'h0006_0000);
        set_order(15);
        send_matrix(Order);
        set_order(1);
        send_element(32'hdead_beef);
    endtask

    // Random matrices of small order
    task automatic test_random(int pct);
        int n;
        idle_pct = pct;
        for (int m = 0; m < 2; m++)
        begin
            n = $urandom_range(3, 1);
            set_order(n);
            send_matrix(n);
        end
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        factor_beat_t want;
        if (rst_n && valid)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_beats.pop_front();
                if (lu_value !== want.lu_value)
                    report_mismatch($sformatf("lu_value %h want %h", lu_value, want.lu_value));
                if (row !== want.row)
                    report_mismatch($sformatf("row %0d want %0d", row, want.row));
                if (col !== want.col)
                    report_mismatch($sformatf("col %0d want %0d", col, want.col));
                if (pivot_row !== want.pivot_row)
                    report_mismatch($sformatf("pivot_row %0d want %0d",
                                              pivot_row, want.pivot_row));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d want %0d", last, want.last));
            end
        end
    end

    // Watchdog: count cycles with no beat accepted in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || valid || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogMax)
        begin
            $display("lu_partial_pivot_factor_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        element = '0;
        quiet_cycles = 0;
        error_count = 0;
        idle_pct = 0;
        order_sel = Order;
        fill_count = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0);
        test_random(51);
        test_random(15);
        test_random(0);
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("lu_partial_pivot_factor_tb: PASS");
        else
            $display("lu_partial_pivot_factor_tb: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
src/lupf_pkg.sv
src/lupf_ram.sv
src/lupf_div.sv
src/lu_partial_pivot_factor.sv
src/lupf_checker.sv
tb/sv/lu_partial_pivot_factor_tb.sv
